### rtl/lev_pkg.sv
`timescale 1ns / 1ps

package lev_pkg;

    localparam int MAX_LEN = 32;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int SYM_W   = 8;
    localparam int OP_W    = 2;
    localparam int DIST_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    // operands of one row entry update
    typedef struct packed {
        logic [LEN_W-1:0] up;
        logic [LEN_W-1:0] left;
        logic [LEN_W-1:0] diag;
        logic [SYM_W-1:0] ref_sym;
        logic [SYM_W-1:0] query_sym;
    } t_cell_in;

endpackage

### rtl/levenshtein_distance_core.sv
`timescale 1ns / 1ps
// Append and unused op items leave stall low.
// A query byte sweeps the row one entry per cycle
// through the shared update cell, fed by the registered row/reference reads.
// A finish item reads the row, then loads the output register; the load
// waits while a previous result is still held by output stall.
// Synchronous active-low reset clears lengths, overflow, FSM and output valid;
// the row reads as its index values until the first query byte is applied.
module levenshtein_distance_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lev_pkg::OP_W-1:0]      i_op,
    input  logic [lev_pkg::SYM_W-1:0]     i_symbol,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lev_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_overflow
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_FIN   = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [lev_pkg::LEN_W-1:0]    r_ref_len, n_ref_len;
    logic [lev_pkg::LEN_W-1:0]    r_q_len, n_q_len;
    logic                         r_ovf, n_ovf;
    logic                         r_o_valid, n_o_valid;
    logic [lev_pkg::LEN_W-1:0]    r_j, n_j;
    logic [lev_pkg::LEN_W-1:0]    r_diag, n_diag;
    logic [lev_pkg::LEN_W-1:0]    r_left, n_left;
    logic [lev_pkg::SYM_W-1:0]    r_sym, n_sym;
    logic                         r_first, n_first;
    logic [lev_pkg::DIST_W-1:0]   r_o_distance, n_o_distance;
    logic                         r_o_overflow, n_o_overflow;

    logic [lev_pkg::LEN_W-1:0]    mem_row [lev_pkg::MAX_LEN];
    logic [lev_pkg::SYM_W-1:0]    mem_ref [lev_pkg::MAX_LEN];
    logic [lev_pkg::LEN_W-1:0]    r_row_q;
    logic [lev_pkg::SYM_W-1:0]    r_ref_q;

    logic                         in_xfer;
    logic                         ref_we;
    logic                         row_we;
    logic [lev_pkg::ADDR_W-1:0]   wr_addr;
    logic [lev_pkg::ADDR_W-1:0]   rd_addr;
    logic [lev_pkg::LEN_W-1:0]    ref_len_m1;
    logic [lev_pkg::LEN_W-1:0]    j_m1;
    lev_pkg::t_cell_in            cell_in;
    logic [lev_pkg::LEN_W-1:0]    cell_value;

    assign o_stall    = (r_state != S_IDLE);
    assign in_xfer    = i_valid && !o_stall;
    assign o_valid    = r_o_valid;
    assign o_distance = r_o_distance;
    assign o_overflow = r_o_overflow;
    assign ref_len_m1 = r_ref_len - lev_pkg::LEN_W'(1);
    assign j_m1       = r_j - lev_pkg::LEN_W'(1);

    always_comb begin
        cell_in.up        = r_first ? r_j : r_row_q;
        cell_in.left      = r_left;
        cell_in.diag      = r_diag;
        cell_in.ref_sym   = r_ref_q;
        cell_in.query_sym = r_sym;
    end

    lev_cell u_cell (
        .i_cell  (cell_in),
        .o_value (cell_value)
    );

    always_comb begin
        n_state      = r_state;
        n_ref_len    = r_ref_len;
        n_q_len      = r_q_len;
        n_ovf        = r_ovf;
        n_o_valid    = r_o_valid && i_stall;
        n_j          = r_j;
        n_diag       = r_diag;
        n_left       = r_left;
        n_sym        = r_sym;
        n_first      = r_first;
        n_o_distance = r_o_distance;
        n_o_overflow = r_o_overflow;
        ref_we       = 1'b0;
        row_we       = 1'b0;
        wr_addr      = j_m1[lev_pkg::ADDR_W-1:0];
        rd_addr      = r_j[lev_pkg::ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_op)
                        lev_pkg::OP_APPEND: begin
                            // drop reference bytes once the query has begun
                            if (r_q_len == '0) begin
                                if (r_ref_len >= lev_pkg::LEN_W'(lev_pkg::MAX_LEN)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    ref_we    = 1'b1;
                                    n_ref_len = r_ref_len + lev_pkg::LEN_W'(1);
                                end
                            end
                        end
                        lev_pkg::OP_QUERY: begin
                            if (r_q_len >= lev_pkg::LEN_W'(lev_pkg::MAX_LEN)) begin
                                n_ovf = 1'b1;
                            end else begin
                                // entry 0 always equals the query length
                                n_q_len = r_q_len + lev_pkg::LEN_W'(1);
                                n_diag  = r_q_len;
                                n_left  = r_q_len + lev_pkg::LEN_W'(1);
                                n_sym   = i_symbol;
                                n_first = (r_q_len == '0);
                                n_j     = lev_pkg::LEN_W'(1);
                                rd_addr = '0;
                                if (r_ref_len != '0) begin
                                    n_state = S_SWEEP;
                                end
                            end
                        end
                        lev_pkg::OP_FINISH: begin
                            rd_addr = ref_len_m1[lev_pkg::ADDR_W-1:0];
                            n_state = S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                row_we  = 1'b1;
                n_diag  = cell_in.up;
                n_left  = cell_value;
                n_j     = r_j + lev_pkg::LEN_W'(1);
                if (r_j == r_ref_len) begin
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                // hold the last row entry on the read port while waiting
                rd_addr = ref_len_m1[lev_pkg::ADDR_W-1:0];
                // hold until the output register is free
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    if (r_ref_len == '0) begin
                        n_o_distance = lev_pkg::DIST_W'(r_q_len);
                    end else if (r_q_len == '0) begin
                        n_o_distance = lev_pkg::DIST_W'(r_ref_len);
                    end else begin
                        n_o_distance = lev_pkg::DIST_W'(r_row_q);
                    end
                    n_o_overflow = r_ovf;
                    n_ref_len    = '0;
                    n_q_len      = '0;
                    n_ovf        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ref_len <= '0;
            r_q_len   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ref_len <= n_ref_len;
            r_q_len   <= n_q_len;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_diag       <= n_diag;
        r_left       <= n_left;
        r_sym        <= n_sym;
        r_first      <= n_first;
        r_o_distance <= n_o_distance;
        r_o_overflow <= n_o_overflow;
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) begin
            mem_ref[r_ref_len[lev_pkg::ADDR_W-1:0]] <= i_symbol;
        end
        r_ref_q <= mem_ref[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            mem_row[wr_addr] <= cell_value;
        end
        r_row_q <= mem_row[rd_addr];
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref_len <= lev_pkg::LEN_W'(lev_pkg::MAX_LEN))
        && (r_q_len <= lev_pkg::LEN_W'(lev_pkg::MAX_LEN)))
        else $error("string length beyond maximum");

    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_j != '0) && (r_j <= r_ref_len)))
        else $error("sweep index outside reference");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_FIN))
        else $error("result without finish");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_distance <= lev_pkg::DIST_W'(lev_pkg::MAX_LEN)))
        else $error("distance beyond maximum length");

endmodule

### rtl/lev_cell.sv
`timescale 1ns / 1ps

module lev_cell (
    input  lev_pkg::t_cell_in               i_cell,
    output logic [lev_pkg::LEN_W-1:0]       o_value
);

    logic [lev_pkg::LEN_W:0] up_cost;
    logic [lev_pkg::LEN_W:0] left_cost;
    logic [lev_pkg::LEN_W:0] diag_cost;
    logic [lev_pkg::LEN_W:0] min_ul;
    logic [lev_pkg::LEN_W:0] min_all;

    always_comb begin
        up_cost   = {1'b0, i_cell.up} + (lev_pkg::LEN_W + 1)'(1);
        left_cost = {1'b0, i_cell.left} + (lev_pkg::LEN_W + 1)'(1);
        diag_cost = {1'b0, i_cell.diag}
                  + (lev_pkg::LEN_W + 1)'(i_cell.ref_sym != i_cell.query_sym);
        min_ul    = (up_cost < left_cost) ? up_cost : left_cost;
        min_all   = (min_ul < diag_cost) ? min_ul : diag_cost;
        // result never exceeds the row index bound, so the top bit is zero
        o_value   = min_all[lev_pkg::LEN_W-1:0];
    end

endmodule
